// ===== hdl/cosine_similarity_engine_defines.svh =====
// assertion macros used by the cosine similarity engine controller
`ifndef COSINE_SIMILARITY_ENGINE_DEFINES_SVH
`define COSINE_SIMILARITY_ENGINE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication check
`define CSE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cse assertion failed");

// next-cycle implication check
`define CSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cse assertion failed");

`else

`define CSE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define CSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/cse_pkg.sv =====
// shared types and constants of the cosine similarity engine
package cse_pkg;

    // field widths
    localparam int IN_W      = 16;
    localparam int DOT_W     = 44;
    localparam int SQ_W      = 43;
    localparam int COS_W     = 16;
    localparam int CNT_OUT_W = 13;

    // root and divide widths
    localparam int SQ_SHIFT  = 20;
    localparam int RAD_W     = SQ_W + SQ_SHIFT;
    localparam int ROOT_W    = 32;
    localparam int DEN_W     = 2 * ROOT_W;
    localparam int DIV_SHIFT = DEN_W - 1 - DOT_W;
    localparam int Q_W       = 17;

    // sequencer step counts
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(Q_W - 1);

    // saturation limit of the cosine magnitude
    localparam logic [COS_W-1:0] COS_MAX = 16'h7fff;

    // stream packing
    localparam int S_TDATA_W = 2 * IN_W;
    localparam int M_TDATA_W = 80;
    localparam int M_PAD_W   = M_TDATA_W - DOT_W - COS_W - CNT_OUT_W;
    localparam int M_TUSER_W = 2;

    // commands from controller to datapath
    typedef struct packed {
        logic prod_load;
        logic acc_en;
        logic acc_clear;
        logic root_load;
        logic root_step;
        logic den_load;
        logic div_init;
        logic div_step;
        logic out_load;
    } cse_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic zero_norm;
    } cse_status_t;

endpackage

// ===== hdl/cse_root.sv =====
// bit-serial integer square root, one result bit per step
module cse_root
(
    input  logic                         clk,
    input  logic                         load,
    input  logic                         step,
    input  logic [cse_pkg::RAD_W-1:0]    radicand,
    output logic [cse_pkg::ROOT_W-1:0]   root
);

    logic [cse_pkg::RAD_W-1:0] rem_reg;
    logic [cse_pkg::RAD_W-1:0] res_reg;
    logic [cse_pkg::RAD_W-1:0] bit_reg;
    logic [cse_pkg::RAD_W:0]   trial;
    logic                      fits;

    // trial subtraction of the current root candidate
    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign fits  = {1'b0, rem_reg} >= trial;

    // iteration registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= {1'b1, {(cse_pkg::RAD_W-1){1'b0}}};
        end
        else if (step)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - trial[cse_pkg::RAD_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = res_reg[cse_pkg::ROOT_W-1:0];

endmodule

// ===== hdl/cse_ctrl.sv =====
// controller state machine: input flow, root and divide sequencing, result hand-off
`include "cosine_similarity_engine_defines.svh"

module cse_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  cse_pkg::cse_status_t status,
    output cse_pkg::cse_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_ACCUM   = 7'b0000001,
        ST_LOAD    = 7'b0000010,
        ST_ROOT    = 7'b0000100,
        ST_MUL     = 7'b0001000,
        ST_DIVINIT = 7'b0010000,
        ST_DIV     = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [cse_pkg::STEP_W-1:0]  step_cnt_reg, step_cnt_next;
    logic                        prod_valid_reg;
    logic                        prod_last_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        s_fire;
    logic                        out_free;

    // input side: stop taking pairs once the last one sits in the product stage
    assign s_tready = (state_reg == ST_ACCUM) && !(prod_valid_reg && prod_last_reg);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        cmd.prod_load = s_fire;
        case (state_reg)
            ST_ACCUM:
            begin
                cmd.acc_en = prod_valid_reg;
                if (prod_valid_reg && prod_last_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.root_load = 1'b1;
                step_cnt_next = '0;
                state_next    = status.zero_norm ? ST_DONE : ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == cse_pkg::ROOT_LAST)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.den_load = 1'b1;
                state_next   = ST_DIVINIT;
            end
            ST_DIVINIT:
            begin
                cmd.div_init  = 1'b1;
                step_cnt_next = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == cse_pkg::DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.acc_clear = 1'b1;
                    state_next    = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ACCUM;
            step_cnt_reg   <= '0;
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_cnt_reg   <= step_cnt_next;
            prod_valid_reg <= s_fire;
            prod_last_reg  <= s_fire && s_tlast;
            out_valid_reg  <= out_valid_next;
        end
    end

    // checks
    `CSE_ASSERT_NEXT(a_no_take_after_last, clk, rst_n, s_fire && s_tlast, !s_tready)
    `CSE_ASSERT_IMPLIES(a_result_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_DONE))
    `CSE_ASSERT_IMPLIES(a_mul_after_root, clk, rst_n, state_reg == ST_MUL, $past(state_reg == ST_ROOT))
    `CSE_ASSERT_IMPLIES(a_no_pair_in_flight, clk, rst_n, state_reg != ST_ACCUM, !prod_valid_reg)

endmodule

// ===== hdl/cse_datapath.sv =====
// datapath: multiply-accumulate, norms, divide, cosine rounding and result register
module cse_datapath
#(
    parameter int MAX_ELEMENTS  = 4096,
    parameter int ELEMENT_WIDTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cse_pkg::cse_cmd_t                   cmd,
    output cse_pkg::cse_status_t                status,
    input  logic [cse_pkg::IN_W-1:0]            elem_a,
    input  logic [cse_pkg::IN_W-1:0]            elem_b,
    output logic signed [cse_pkg::DOT_W-1:0]    dot_product,
    output logic signed [cse_pkg::COS_W-1:0]    cosine,
    output logic                                zero_norm,
    output logic                                length_overflow,
    output logic [cse_pkg::CNT_OUT_W-1:0]       element_count
);

    // wider elements keep the 16 input bits as a positive value
    localparam int EW    = (ELEMENT_WIDTH > cse_pkg::IN_W) ? cse_pkg::IN_W + 1 : ELEMENT_WIDTH;
    localparam int PW    = 2 * EW;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    logic signed [EW-1:0]                a_w, b_w;
    logic signed [PW-1:0]                prod_ab_reg, prod_aa_reg, prod_bb_reg;
    logic signed [cse_pkg::DOT_W-1:0]    dot_reg;
    logic [cse_pkg::SQ_W-1:0]            sq_a_reg, sq_b_reg;
    logic [CNT_W-1:0]                    cnt_reg;
    logic                                ovf_reg;
    logic                                count_full;
    logic [cse_pkg::ROOT_W-1:0]          root_a, root_b;
    logic [cse_pkg::DEN_W-1:0]           den_reg, den_next;
    logic [cse_pkg::DEN_W-1:0]           rem_reg, rem_init, rem_shift;
    logic [cse_pkg::Q_W-1:0]             q_reg;
    logic                                sat_reg;
    logic                                neg;
    logic [cse_pkg::DOT_W-1:0]           mag;
    logic [cse_pkg::Q_W:0]               m_round;
    logic [cse_pkg::COS_W-1:0]           m_cos;
    logic [cse_pkg::COS_W-1:0]           cos_value;

    // element width selection
    generate
        if (ELEMENT_WIDTH > cse_pkg::IN_W)
        begin : g_wide
            assign a_w = $signed({1'b0, elem_a});
            assign b_w = $signed({1'b0, elem_b});
        end
        else
        begin : g_narrow
            assign a_w = elem_a[EW-1:0];
            assign b_w = elem_b[EW-1:0];
        end
    endgenerate

    // product stage
    always_ff @(posedge clk)
    begin
        if (cmd.prod_load)
        begin
            prod_ab_reg <= a_w * b_w;
            prod_aa_reg <= a_w * a_w;
            prod_bb_reg <= b_w * b_w;
        end
    end

    assign count_full = cnt_reg >= CNT_W'(MAX_ELEMENTS);

    // running sums, pair count and overflow mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            sq_a_reg <= '0;
            sq_b_reg <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.acc_clear)
        begin
            dot_reg  <= '0;
            sq_a_reg <= '0;
            sq_b_reg <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (count_full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                dot_reg  <= dot_reg + cse_pkg::DOT_W'(prod_ab_reg);
                sq_a_reg <= sq_a_reg + cse_pkg::SQ_W'(prod_aa_reg);
                sq_b_reg <= sq_b_reg + cse_pkg::SQ_W'(prod_bb_reg);
                cnt_reg  <= cnt_reg + 1'b1;
            end
        end
    end

    assign status.zero_norm = (sq_a_reg == '0) || (sq_b_reg == '0);

    // norms of both vectors, in parallel
    cse_root u_root_a
    (
        .clk      (clk),
        .load     (cmd.root_load),
        .step     (cmd.root_step),
        .radicand ({sq_a_reg, {cse_pkg::SQ_SHIFT{1'b0}}}),
        .root     (root_a)
    );

    cse_root u_root_b
    (
        .clk      (clk),
        .load     (cmd.root_load),
        .step     (cmd.root_step),
        .radicand ({sq_b_reg, {cse_pkg::SQ_SHIFT{1'b0}}}),
        .root     (root_b)
    );

    // magnitude of the dot product
    assign neg = dot_reg[cse_pkg::DOT_W-1];
    assign mag = neg ? cse_pkg::DOT_W'(-dot_reg) : cse_pkg::DOT_W'(dot_reg);

    // norm product
    assign den_next = root_a * root_b;

    always_ff @(posedge clk)
    begin
        if (cmd.den_load)
        begin
            den_reg <= den_next;
        end
    end

    // restoring divide, one quotient bit per step
    assign rem_init  = {1'b0, mag, {cse_pkg::DIV_SHIFT{1'b0}}};
    assign rem_shift = {rem_reg[cse_pkg::DEN_W-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= rem_init;
            q_reg   <= '0;
            sat_reg <= rem_init >= den_reg;
        end
        else if (cmd.div_step)
        begin
            if (rem_shift >= den_reg)
            begin
                rem_reg <= rem_shift - den_reg;
                q_reg   <= {q_reg[cse_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                q_reg   <= {q_reg[cse_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    // round half up, saturate, apply sign; zero when a norm is zero
    assign m_round = ({1'b0, q_reg} + 1'b1) >> 1;
    assign m_cos   = (sat_reg || (m_round > (cse_pkg::Q_W+1)'(cse_pkg::COS_MAX)))
                   ? cse_pkg::COS_MAX : m_round[cse_pkg::COS_W-1:0];

    always_comb
    begin
        if (status.zero_norm)
        begin
            cos_value = '0;
        end
        else if (neg)
        begin
            cos_value = -m_cos;
        end
        else
        begin
            cos_value = m_cos;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            dot_product     <= dot_reg;
            cosine          <= cos_value;
            zero_norm       <= status.zero_norm;
            length_overflow <= ovf_reg;
            element_count   <= cse_pkg::CNT_OUT_W'(cnt_reg);
        end
    end

endmodule

// ===== hdl/cosine_similarity_engine.sv =====
// top level of the streaming cosine similarity engine
//
// Element pairs (a, b) stream in at one transfer per cycle while the input is
// ready; each pair is multiplied in a product stage and added into the dot
// product and the two sums of squares on the next cycle. After the pair marked
// tlast the input stalls while the engine finishes the vector: the last
// product is added, the root units are loaded, the bit-serial square root runs
// (both norms in parallel), the norm product is registered, the restoring
// divide is set up and run, and the result register is loaded. If either sum
// of squares is zero the root and divide are skipped. The result register lets
// the next vector stream in while a result waits to be taken; a finished
// vector only holds in its last step while the previous result is still
// waiting.
module cosine_similarity_engine
#(
    parameter int MAX_ELEMENTS  = 4096,
    parameter int ELEMENT_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // elem_a [15:0], elem_b [31:16]
    input  logic [cse_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // dot_product [43:0], cosine [59:44], element_count [72:60], zero pad [79:73]
    output logic [cse_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // zero_norm [0], length_overflow [1]
    output logic [cse_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    cse_pkg::cse_cmd_t                       cmd;
    cse_pkg::cse_status_t                    status;
    logic signed [cse_pkg::DOT_W-1:0]        dot_product;
    logic signed [cse_pkg::COS_W-1:0]        cosine;
    logic                                    zero_norm;
    logic                                    length_overflow;
    logic [cse_pkg::CNT_OUT_W-1:0]           element_count;

    // sequencing
    cse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tlast  (s_axis_tlast),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic
    cse_datapath
    #(
        .MAX_ELEMENTS  (MAX_ELEMENTS),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .elem_a          (s_axis_tdata[cse_pkg::IN_W-1:0]),
        .elem_b          (s_axis_tdata[cse_pkg::S_TDATA_W-1:cse_pkg::IN_W]),
        .dot_product     (dot_product),
        .cosine          (cosine),
        .zero_norm       (zero_norm),
        .length_overflow (length_overflow),
        .element_count   (element_count)
    );

    // result packing
    assign m_axis_tdata = {{cse_pkg::M_PAD_W{1'b0}}, element_count, cosine, dot_product};
    assign m_axis_tuser = {length_overflow, zero_norm};

endmodule

// ===== dv/tb_cosine_similarity_engine.sv =====
// self-checking testbench for the streaming cosine similarity engine
`timescale 1ns / 1ps

module tb_cosine_similarity_engine;

    localparam int IN_W      = cse_pkg::IN_W;
    localparam int DOT_W     = cse_pkg::DOT_W;
    localparam int SQ_W      = cse_pkg::SQ_W;
    localparam int COS_W     = cse_pkg::COS_W;
    localparam int CNT_OUT_W = cse_pkg::CNT_OUT_W;
    localparam int S_TDATA_W = cse_pkg::S_TDATA_W;
    localparam int M_TDATA_W = cse_pkg::M_TDATA_W;
    localparam int M_TUSER_W = cse_pkg::M_TUSER_W;
    localparam logic [COS_W-1:0] COS_MAX = cse_pkg::COS_MAX;

    localparam int MAX_PAIRS    = 4096;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PAIRS = 550;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_IDLE     = 13;

    // clamp of the scaled quotient before rounding
    localparam logic [63:0] QUOT_CLAMP = 64'h20000;

    // one expected vector result
    typedef struct packed {
        logic [DOT_W-1:0]     dot;
        logic [COS_W-1:0]     cosine;
        logic [CNT_OUT_W-1:0] count;
        logic                 zero_norm;
        logic                 length_ovf;
    } cosine_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // elem_a [15:0], elem_b [31:16]
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // dot_product [43:0], cosine [59:44], element_count [72:60], zero pad [79:73]
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    // zero_norm [0], length_overflow [1]
    logic [M_TUSER_W-1:0]   m_axis_tuser;

    // predictor state
    logic [DOT_W-1:0] dot_sum;
    logic [SQ_W-1:0]  sq_sum_a;
    logic [SQ_W-1:0]  sq_sum_b;
    int unsigned      pairs_taken;
    logic             ovf_seen;

    cosine_result_t expected_results[$];

    // run bookkeeping
    int  error_count;
    int  pairs_sent;
    int  vectors_sent;
    int  results_checked;
    int  zero_norm_seen;
    int  overflow_seen;
    int  cycle_count;
    int  rx_wait;
    bit  tx_idle_en;
    bit  rx_idle_en;

    cosine_similarity_engine DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // integer square root, floor
    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] one;
        begin
            res = '0;
            one = 64'h4000_0000_0000_0000;
            while (one > x)
                one = one >> 2;
            while (one != 0)
            begin
                if (x >= res + one)
                begin
                    x   = x - (res + one);
                    res = (res >> 1) + one;
                end
                else
                    res = res >> 1;
                one = one >> 2;
            end
            return res;
        end
    endfunction

    // floor(mag * 2^36 / den) by restoring division, clamped
    function automatic logic [63:0] scaled_quotient(input logic [DOT_W-1:0] mag,
                                                    input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quot;
        logic        din;
        begin
            rem  = '0;
            quot = '0;
            for (int i = 0; i < 80; i++)
            begin
                din  = (i < DOT_W) ? mag[DOT_W-1-i] : 1'b0;
                rem  = {rem[63:0], din};
                quot = quot << 1;
                if (rem >= {1'b0, den})
                begin
                    rem     = rem - {1'b0, den};
                    quot[0] = 1'b1;
                end
                if (quot > QUOT_CLAMP)
                    quot = QUOT_CLAMP;
            end
            return quot;
        end
    endfunction

    // accumulate one accepted pair and queue the vector result on the last one
    task automatic accumulate_pair(input logic signed [IN_W-1:0] a,
                                   input logic signed [IN_W-1:0] b,
                                   input logic is_last);
        logic signed [31:0] prod_ab;
        logic signed [31:0] prod_aa;
        logic signed [31:0] prod_bb;
        logic [DOT_W-1:0]   mag;
        logic [63:0]        root_a;
        logic [63:0]        root_b;
        logic [63:0]        quot;
        logic [63:0]        cos_mag;
        logic               neg;
        cosine_result_t     res;
        begin
            pairs_sent++;
            if (pairs_taken >= MAX_PAIRS)
                ovf_seen = 1'b1;
            else
            begin
                prod_ab  = a * b;
                prod_aa  = a * a;
                prod_bb  = b * b;
                dot_sum  = dot_sum + {{(DOT_W-32){prod_ab[31]}}, prod_ab};
                sq_sum_a = sq_sum_a + {{(SQ_W-32){1'b0}}, prod_aa};
                sq_sum_b = sq_sum_b + {{(SQ_W-32){1'b0}}, prod_bb};
                pairs_taken++;
            end
            if (is_last)
            begin
                res            = '0;
                res.dot        = dot_sum;
                res.count      = CNT_OUT_W'(pairs_taken);
                res.length_ovf = ovf_seen;
                if (sq_sum_a == 0 || sq_sum_b == 0)
                    res.zero_norm = 1'b1;
                else
                begin
                    neg     = dot_sum[DOT_W-1];
                    mag     = neg ? -dot_sum : dot_sum;
                    root_a  = floor_root({1'b0, sq_sum_a, 20'b0});
                    root_b  = floor_root({1'b0, sq_sum_b, 20'b0});
                    quot    = scaled_quotient(mag, root_a * root_b);
                    cos_mag = (quot + 1) >> 1;
                    if (cos_mag > {48'b0, COS_MAX})
                        cos_mag = {48'b0, COS_MAX};
                    res.cosine = neg ? COS_W'(-cos_mag) : COS_W'(cos_mag);
                end
                expected_results = {expected_results, res};
                vectors_sent++;
                dot_sum     = '0;
                sq_sum_a    = '0;
                sq_sum_b    = '0;
                pairs_taken = 0;
                ovf_seen    = 1'b0;
            end
        end
    endtask

    // drive one element pair and wait for its transfer
    task automatic send_pair(input logic signed [IN_W-1:0] a,
                             input logic signed [IN_W-1:0] b,
                             input logic is_last);
        int gap;
        begin
            gap = tx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tdata  <= {b, a};
            s_axis_tlast  <= is_last;
            s_axis_tvalid <= 1'b1;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            accumulate_pair(a, b, is_last);
        end
    endtask

    // one field against its expectation
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                error_count++;
            end
        end
    endtask

    // check one result transfer against the oldest expectation
    task automatic check_result(input logic [M_TDATA_W-1:0] data,
                                input logic [M_TUSER_W-1:0] user);
        cosine_result_t want;
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing, actual %h / %h",
                         $time, data, user);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("dot_product", 64'(want.dot), 64'(data[43:0]));
                compare_field("cosine", 64'(want.cosine), 64'(data[59:44]));
                compare_field("element_count", 64'(want.count), 64'(data[72:60]));
                compare_field("tdata pad", 64'd0, 64'(data[79:73]));
                compare_field("zero_norm", 64'(want.zero_norm), 64'(user[0]));
                compare_field("length_overflow", 64'(want.length_ovf), 64'(user[1]));
                results_checked++;
                if (want.zero_norm)
                    zero_norm_seen++;
                if (want.length_ovf)
                    overflow_seen++;
            end
        end
    endtask

    // result side: random stalls between transfers, check on each transfer
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        int draw;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            check_result(m_axis_tdata, m_axis_tuser);
            draw = rx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            rx_wait       <= draw;
            m_axis_tready <= (draw == 0);
        end
        else if (rx_wait != 0)
        begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // element mix: extremes, zero, small and full range
    function automatic logic [IN_W-1:0] random_element();
        begin
            case ($urandom_range(0, 9))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return '0;
                3, 4, 5: return IN_W'($urandom_range(0, 255)) - 16'd128;
                default: return IN_W'($urandom);
            endcase
        end
    endfunction

    // one-element vectors
    task automatic test_single_pair();
        begin
            send_pair(16'sd1, 16'sd1, 1'b1);
            send_pair(-16'sd4096, 16'sd4096, 1'b1);
        end
    endtask

    // either or both vectors all zero
    task automatic test_zero_norm();
        begin
            send_pair(16'sd0, 16'sd100, 1'b0);
            send_pair(16'sd0, -16'sd7, 1'b0);
            send_pair(16'sd0, 16'sd3, 1'b1);
            send_pair(16'sh7fff, 16'sd0, 1'b0);
            send_pair(16'sh8000, 16'sd0, 1'b1);
            send_pair(16'sd0, 16'sd0, 1'b1);
        end
    endtask

    // largest magnitudes, same and mixed sign
    task automatic test_extremes();
        begin
            send_pair(16'sh7fff, 16'sh7fff, 1'b0);
            send_pair(16'sh7fff, 16'sh7fff, 1'b1);
            send_pair(16'sh8000, 16'sh8000, 1'b0);
            send_pair(16'sh8000, 16'sh8000, 1'b1);
            send_pair(16'sh8000, 16'sh7fff, 1'b0);
            send_pair(16'sh7fff, 16'sh8000, 1'b1);
        end
    endtask

    // opposite, orthogonal and tiny vectors
    task automatic test_signs();
        begin
            send_pair(16'sd1000, -16'sd1000, 1'b0);
            send_pair(-16'sd20, 16'sd20, 1'b0);
            send_pair(16'sd5, -16'sd5, 1'b1);
            send_pair(16'sd4096, 16'sd0, 1'b0);
            send_pair(16'sd0, 16'sd4096, 1'b1);
            send_pair(16'sd1, -16'sd1, 1'b0);
            send_pair(-16'sd1, -16'sd1, 1'b1);
        end
    endtask

    // random vectors of varied shape and length
    task automatic test_random_vectors();
        int                     start;
        int                     len;
        int                     shape;
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        begin
            start = pairs_sent;
            while (pairs_sent - start < RANDOM_PAIRS)
            begin
                tx_idle_en = ($urandom_range(0, 4) != 0);
                rx_idle_en = ($urandom_range(0, 4) != 0);
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                    : $urandom_range(1, 12);
                shape = $urandom_range(0, 9);
                for (int i = 0; i < len; i++)
                begin
                    a = random_element();
                    b = random_element();
                    case (shape)
                        4: b = a;
                        5: b = -a;
                        6: b = a + IN_W'($urandom_range(0, 15)) - 16'sd8;
                        7: a = '0;
                        8: b = '0;
                        9:
                        begin
                            if ($urandom_range(0, 3) != 0)
                            begin
                                a = '0;
                                b = '0;
                            end
                        end
                        default: ;
                    endcase
                    send_pair(a, b, i == len - 1);
                end
            end
            tx_idle_en = 1'b1;
            rx_idle_en = 1'b1;
        end
    endtask

    // stop driving, then let every expected result arrive
    task automatic drain_results();
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tlast  <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // test sequence
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        dot_sum       = '0;
        sq_sum_a      = '0;
        sq_sum_b      = '0;
        pairs_taken   = 0;
        ovf_seen      = 1'b0;
        error_count   = 0;
        pairs_sent    = 0;
        vectors_sent  = 0;
        results_checked = 0;
        zero_norm_seen  = 0;
        overflow_seen   = 0;
        cycle_count   = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_pair();
        test_zero_norm();
        test_extremes();
        test_signs();
        test_random_vectors();
        drain_results();

        $display("covered %0d pairs in %0d vectors, %0d results checked in %0d cycles",
                 pairs_sent, vectors_sent, results_checked, cycle_count);
        $display("%0d results with zero norm, %0d with length overflow",
                 zero_norm_seen, overflow_seen);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cse_pkg.sv
hdl/cse_root.sv
hdl/cse_ctrl.sv
hdl/cse_datapath.sv
hdl/cosine_similarity_engine.sv
dv/tb_cosine_similarity_engine.sv
